### hdl/rpb_pkg.sv
`timescale 1ns / 1ps
package rpb_pkg;

  localparam int CoordW = 16;
  localparam int NumCoords = 4;
  localparam int RowW = 64;
  localparam int SlotW = 6;
  localparam int DimW = 3;
  localparam int ThrW = 35;
  localparam int SqW = 2 * (CoordW + 1);
  localparam int DistW = SqW + 2;

  localparam logic HIT_BIT = 1'b1;
  localparam logic MISS_BIT = 1'b0;

  localparam logic CFG_THRESHOLD_SQ = 1'b0;
  localparam logic CFG_DIMS_USED = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  // Item travelling down the cell chain.
  typedef struct packed {
    logic vld;
    logic ovf;
    logic [SlotW-1:0] slot;
    logic [DimW-1:0] dims;
    coord_t [NumCoords-1:0] pt;
    logic [RowW-1:0] row;
  } probe_t;

endpackage

### hdl/rpb_cell.sv
`timescale 1ns / 1ps
module rpb_cell #(
  parameter int K = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [rpb_pkg::ThrW-1:0] thr_i,
  input  rpb_pkg::probe_t probe_i,
  output rpb_pkg::probe_t probe_o
);

  localparam logic [rpb_pkg::SlotW-1:0] Idx = rpb_pkg::SlotW'(K);

  rpb_pkg::coord_t [rpb_pkg::NumCoords-1:0] pt_q;
  rpb_pkg::coord_t [rpb_pkg::NumCoords-1:0] ref_pt;
  rpb_pkg::probe_t probe_q, probe_d;
  logic [rpb_pkg::DistW-1:0] dist_sum;
  logic hit, mine;

  assign mine = probe_i.vld && !probe_i.ovf && (probe_i.slot == Idx);

  // Own slot compares with the incoming point itself (write-first).
  assign ref_pt = mine ? probe_i.pt : pt_q;

  always_comb begin
    logic signed [rpb_pkg::CoordW:0] diff;
    logic [rpb_pkg::SqW-1:0] sq;
    dist_sum = '0;
    for (int d = 0; d < rpb_pkg::NumCoords; d++) begin
      diff = (rpb_pkg::CoordW+1)'(probe_i.pt[d]) - (rpb_pkg::CoordW+1)'(ref_pt[d]);
      sq = $unsigned(rpb_pkg::SqW'(diff) * rpb_pkg::SqW'(diff));
      if (rpb_pkg::DimW'(d) < probe_i.dims) begin
        dist_sum = dist_sum + rpb_pkg::DistW'(sq);
      end
    end
  end

  assign hit = probe_i.vld && !probe_i.ovf && (Idx <= probe_i.slot)
               && ({1'b0, dist_sum} < {{(rpb_pkg::DistW+1-rpb_pkg::ThrW){1'b0}}, thr_i});

  always_comb begin
    probe_d = probe_i;
    probe_d.row[K] = hit ? rpb_pkg::HIT_BIT : rpb_pkg::MISS_BIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else if (en_i) begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && mine) begin
      pt_q <= probe_i.pt;
    end
  end

  assign probe_o = probe_q;

endmodule

### hdl/recurrence_plot_row_builder.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     new_series_i, coord_0_i..coord_3_i
// out       output     out_valid_o / out_ready_i   row_index_o, row_bits_o, overflow_o
// cfg       input      cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the output is not stalled; each item passes through every cell of the chain.
// Each cell holds one stored point and compares the passing item against it.
// Reset clears the point count, threshold (0) and dims_used (1); stored points are
// not cleared. A stalled output freezes the whole chain, and in_ready_o drops with it.
module recurrence_plot_row_builder #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS = 4,
  parameter int COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [rpb_pkg::ThrW-1:0] cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic new_series_i,
  input  logic signed [15:0] coord_0_i,
  input  logic signed [15:0] coord_1_i,
  input  logic signed [15:0] coord_2_i,
  input  logic signed [15:0] coord_3_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [5:0] row_index_o,
  output logic [63:0] row_bits_o,
  output logic overflow_o
);

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int Sh = rpb_pkg::CoordW - COORD_BITS;
  localparam logic [CntW-1:0] Full = CntW'(MAX_POINTS);
  localparam logic [rpb_pkg::DimW-1:0] MaxDims = rpb_pkg::DimW'(MAX_DIMS);

  logic [rpb_pkg::ThrW-1:0] thr_q;
  logic [rpb_pkg::DimW-1:0] dims_q, dims_eff;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_base;
  logic adv, acc;
  rpb_pkg::probe_t chain [MAX_POINTS+1];
  rpb_pkg::probe_t head;
  rpb_pkg::coord_t [rpb_pkg::NumCoords-1:0] raw;

  assign chain[MAX_POINTS-MAX_POINTS] = head;

  // Whole chain moves together; stalls only when the result is not taken.
  assign adv = !chain[MAX_POINTS].vld || out_ready_i;
  assign in_ready_o = adv;
  assign acc = in_valid_i && adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      dims_q <= rpb_pkg::DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpb_pkg::CFG_THRESHOLD_SQ: thr_q <= cfg_wdata_i;
        rpb_pkg::CFG_DIMS_USED: dims_q <= cfg_wdata_i[rpb_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // dims_used zero acts as one, above MAX_DIMS as MAX_DIMS
  always_comb begin
    dims_eff = dims_q;
    if (dims_eff == '0) dims_eff = rpb_pkg::DimW'(1);
    if (dims_eff > MaxDims) dims_eff = MaxDims;
  end

  assign raw[0] = coord_0_i;
  assign raw[1] = coord_1_i;
  assign raw[2] = coord_2_i;
  assign raw[3] = coord_3_i;

  assign cnt_base = new_series_i ? '0 : cnt_q;

  // Build the item entering cell 0
  always_comb begin
    logic [rpb_pkg::CoordW-1:0] sh;
    head = '0;
    head.vld = acc;
    head.dims = dims_eff;
    head.ovf = (cnt_base >= Full);
    head.slot = head.ovf ? '0 : rpb_pkg::SlotW'(cnt_base);
    for (int d = 0; d < rpb_pkg::NumCoords; d++) begin
      sh = raw[d] << Sh;
      if (d < MAX_DIMS) begin
        head.pt[d] = $signed(sh) >>> Sh;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (acc) begin
      cnt_d = (cnt_base >= Full) ? cnt_base : cnt_base + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    rpb_cell #(.K(k)) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .en_i(adv),
      .thr_i(thr_q),
      .probe_i(chain[k]),
      .probe_o(chain[k+1])
    );
  end

  assign out_valid_o = chain[MAX_POINTS].vld;
  assign row_index_o = chain[MAX_POINTS].slot;
  assign row_bits_o = chain[MAX_POINTS].row;
  assign overflow_o = chain[MAX_POINTS].ovf;

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (row_bits_o == '0 && row_index_o == '0))
    else $error("overflow row not empty");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((row_bits_o >> row_index_o) >> 1) == '0)
    else $error("bits above row index");

  a_new_series: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && new_series_i) |=> cnt_q == CntW'(1))
    else $error("series restart count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("point count out of range");

endmodule
